// ===== rtl/rgb_led_matrix_bit_angle_scanner_assert.svh =====
// ----------------------------------------------------------------------------
// RGB LED matrix scanner assertion macros
// Shorthand for the concurrent checks that the scanner's checker uses.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_BIT_ANGLE_SCANNER_ASSERT_SVH
`define RGB_LED_MATRIX_BIT_ANGLE_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define RLMBAS_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define RLMBAS_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

// The consequent must hold in the cycle after a reset cycle.
`define RLMBAS_ASSERT_AFTER_RESET(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/rlmbas_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB LED matrix scanner package
// Item types, command type, default sizes and the bit plane helper.
// ----------------------------------------------------------------------------
package rlmbas_pkg;

  localparam int DEF_LED_COUNT  = 256;
  localparam int DEF_ROW_COUNT  = 8;
  localparam int DEF_COLOR_BITS = 8;

  localparam int MAX_LED_COUNT = 1024;
  localparam int MAX_ROW_COUNT = 32;

  localparam int PIXEL_W     = 8;
  localparam int ROW_W       = 3;
  localparam int PLANE_W     = 3;
  localparam int LANES       = 8;
  localparam int NUM_STORES  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int CMD_ROW_W = $clog2(MAX_ROW_COUNT);
  localparam int CMD_COL_W = $clog2(MAX_LED_COUNT * 3);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [PIXEL_W-1:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_byte;
    logic [ROW_W-1:0]   row;
    logic [PLANE_W-1:0] plane_bit;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                 tick;
    logic                 wen;
    logic                 frame_end;
    logic [CMD_ROW_W-1:0] row;
    logic [CMD_COL_W-1:0] col;
    logic [PIXEL_W-1:0]   pixel;
  } cmd_t;

  // Position of the highest set bit of a nonzero value.
  function automatic logic [PLANE_W-1:0] plane_of(input logic [PIXEL_W-1:0] v);
    logic [PLANE_W-1:0] p;
    p = '0;
    for (int i = 1; i < PIXEL_W; i++) begin
      if (v[i]) begin
        p = PLANE_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/rlmbas_front.sv =====
// ----------------------------------------------------------------------------
// RGB LED matrix scanner front end
// Accepts items, tracks the load write position and issues commands.
// ----------------------------------------------------------------------------
module rlmbas_front import rlmbas_pkg::*; #(
  parameter int LED_COUNT = DEF_LED_COUNT,
  parameter int ROW_COUNT = DEF_ROW_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  input  logic     clear_busy,
  output logic     push,
  output cmd_t     push_cmd
);

  localparam int FRAME_BYTES  = LED_COUNT * 3;
  localparam int LEDS_PER_ROW = LED_COUNT / ROW_COUNT;
  localparam int ROW_BITS     = LEDS_PER_ROW * 3;
  localparam int POS_W        = $clog2(FRAME_BYTES);
  localparam int WROW_W       = $clog2(ROW_COUNT + 1);
  localparam int COL_W        = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
  localparam bit ROW_HAS_BITS = (ROW_BITS != 0);

  logic [POS_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [WROW_W-1:0] wr_row_r, wr_row_nxt;
  logic [COL_W-1:0]  wr_col_r, wr_col_nxt;
  logic              is_load;
  logic              row_ok;
  logic              at_frame_end;

  assign in_stall     = q_full || clear_busy;
  assign push         = in_valid && !in_stall;
  assign is_load      = (in_item.kind == KIND_LOAD);
  assign row_ok       = ROW_HAS_BITS && (wr_row_r < WROW_W'(ROW_COUNT));
  assign at_frame_end = (wr_pos_r == POS_W'(FRAME_BYTES - 1));

  always_comb begin
    push_cmd.tick      = (in_item.kind == KIND_TICK);
    push_cmd.wen       = is_load && row_ok;
    push_cmd.frame_end = is_load && at_frame_end;
    push_cmd.row       = CMD_ROW_W'(wr_row_r);
    push_cmd.col       = CMD_COL_W'(wr_col_r);
    push_cmd.pixel     = in_item.pixel_byte;
  end

  always_comb begin
    wr_pos_nxt = wr_pos_r;
    wr_row_nxt = wr_row_r;
    wr_col_nxt = wr_col_r;
    if (push && is_load) begin
      if (at_frame_end) begin
        wr_pos_nxt = '0;
        wr_row_nxt = '0;
        wr_col_nxt = '0;
      end else begin
        wr_pos_nxt = wr_pos_r + 1'b1;
        if (row_ok) begin
          if (wr_col_r == COL_W'(ROW_BITS - 1)) begin
            wr_col_nxt = '0;
            wr_row_nxt = wr_row_r + 1'b1;
          end else begin
            wr_col_nxt = wr_col_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      wr_row_r <= '0;
      wr_col_r <= '0;
    end else begin
      wr_pos_r <= wr_pos_nxt;
      wr_row_r <= wr_row_nxt;
      wr_col_r <= wr_col_nxt;
    end
  end

endmodule

// ===== rtl/rlmbas_queue.sv =====
// ----------------------------------------------------------------------------
// RGB LED matrix scanner command queue
// Short FIFO between the front end and the scan engine.
// ----------------------------------------------------------------------------
module rlmbas_queue import rlmbas_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/rlmbas_back.sv =====
// ----------------------------------------------------------------------------
// RGB LED matrix scanner engine
// Holds the three frame stores, writes loads, and shifts out rows on ticks.
// ----------------------------------------------------------------------------
module rlmbas_back import rlmbas_pkg::*; #(
  parameter int LED_COUNT  = DEF_LED_COUNT,
  parameter int ROW_COUNT  = DEF_ROW_COUNT,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      clear_busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int LEDS_PER_ROW = LED_COUNT / ROW_COUNT;
  localparam int ROW_BITS     = LEDS_PER_ROW * 3;
  localparam int ROW_BYTES    = (ROW_BITS + 7) / 8;
  localparam bit ROW_EMPTY    = (ROW_BYTES == 0);
  localparam int ROW_WORDS    = ROW_EMPTY ? 1 : ROW_BYTES;
  localparam int STORE_WORDS  = ROW_COUNT * ROW_WORDS;
  localparam int MEM_WORDS    = NUM_STORES * STORE_WORDS;
  localparam int ADDR_W       = $clog2(MEM_WORDS);
  localparam int WORD_W       = LANES * COLOR_BITS;
  localparam int T_W          = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int SROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int REP_LAST     = (1 << COLOR_BITS) - 2;
  localparam int TAIL_BITS    = ROW_BITS % 8;
  localparam logic [LANES-1:0] LAST_MASK =
    (TAIL_BITS == 0) ? '1 : LANES'((1 << TAIL_BITS) - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
    logic               last;
    logic [LANES-1:0]   mask;
  } meta_t;

  logic [WORD_W-1:0] pix_mem_r [MEM_WORDS];

  logic [1:0]            st_r, st_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [T_W-1:0]        t_r, t_nxt;
  logic [1:0]            recv_sel_r, recv_sel_nxt;
  logic [1:0]            ready_sel_r, ready_sel_nxt;
  logic [1:0]            disp_sel_r, disp_sel_nxt;
  logic                  pending_r, pending_nxt;
  logic [SROW_W-1:0]     srow_r, srow_nxt;
  logic [COLOR_BITS-1:0] rep_r, rep_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  meta_t                 rd_meta_r;
  logic [WORD_W-1:0]     rd_data_r;
  out_item_t             out_item_r;

  logic                  is_clear;
  logic                  rd_take;
  logic                  issue_ok;
  logic                  start_tick;
  logic                  do_load;
  logic                  issue;
  logic                  advance;
  logic [T_W-1:0]        word;
  logic                  last_word;
  logic [PLANE_W-1:0]    plane_now;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic                  mem_we;
  logic [LANES-1:0]      mem_wbe;
  logic [COLOR_BITS-1:0] mem_wdata;
  meta_t                 meta_now;
  logic [PIXEL_W-1:0]    shift_byte;

  assign is_clear   = (st_r == ST_CLEAR);
  assign clear_busy = is_clear;
  assign rd_take    = rd_vld_r && (!out_valid_r || !out_stall);
  assign issue_ok   = !rd_vld_r || rd_take;
  assign q_pop      = (st_r == ST_IDLE) && q_valid && (!q_cmd.tick || issue_ok || ROW_EMPTY);
  assign start_tick = q_pop && q_cmd.tick;
  assign do_load    = q_pop && !q_cmd.tick;
  assign issue      = !ROW_EMPTY && (start_tick || ((st_r == ST_SCAN) && issue_ok));
  assign word       = (st_r == ST_SCAN) ? t_r : '0;
  assign last_word  = (word == T_W'(ROW_WORDS - 1));
  assign advance    = (start_tick && ROW_EMPTY) || (issue && last_word);
  assign plane_now  = plane_of(PIXEL_W'(rep_r) + PIXEL_W'(1));

  assign raddr = ADDR_W'(disp_sel_r) * ADDR_W'(STORE_WORDS)
               + ADDR_W'(srow_r) * ADDR_W'(ROW_WORDS)
               + ADDR_W'(word);

  assign waddr = is_clear ? clr_r
               : ADDR_W'(recv_sel_r) * ADDR_W'(STORE_WORDS)
               + ADDR_W'(q_cmd.row) * ADDR_W'(ROW_WORDS)
               + ADDR_W'(q_cmd.col[CMD_COL_W-1:3]);

  assign mem_we    = is_clear || (do_load && q_cmd.wen);
  assign mem_wbe   = is_clear ? '1 : (LANES'(1) << q_cmd.col[2:0]);
  assign mem_wdata = is_clear ? '0 : q_cmd.pixel[COLOR_BITS-1:0];

  always_comb begin
    meta_now.row   = ROW_W'(srow_r);
    meta_now.plane = plane_now;
    meta_now.last  = last_word;
    meta_now.mask  = last_word ? LAST_MASK : '1;
  end

  always_comb begin
    logic [COLOR_BITS-1:0] lane_v;
    shift_byte = '0;
    for (int b = 0; b < LANES; b++) begin
      lane_v = rd_data_r[b*COLOR_BITS +: COLOR_BITS] >> rd_meta_r.plane;
      shift_byte[LANES-1-b] = lane_v[0] & rd_meta_r.mask[b];
    end
  end

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    t_nxt         = t_r;
    recv_sel_nxt  = recv_sel_r;
    ready_sel_nxt = ready_sel_r;
    disp_sel_nxt  = disp_sel_r;
    pending_nxt   = pending_r;
    srow_nxt      = srow_r;
    rep_nxt       = rep_r;

    unique case (st_r) inside
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MEM_WORDS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE, ST_SCAN: begin
        if (issue) begin
          if (last_word) begin
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_SCAN;
            t_nxt  = word + 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (do_load && q_cmd.frame_end) begin
      recv_sel_nxt  = ready_sel_r;
      ready_sel_nxt = recv_sel_r;
      pending_nxt   = 1'b1;
    end

    if (advance) begin
      if (srow_r == SROW_W'(ROW_COUNT - 1)) begin
        srow_nxt = '0;
        if (rep_r == COLOR_BITS'(REP_LAST)) begin
          rep_nxt = '0;
          if (pending_r) begin
            pending_nxt   = 1'b0;
            disp_sel_nxt  = ready_sel_r;
            ready_sel_nxt = disp_sel_r;
          end
        end else begin
          rep_nxt = rep_r + 1'b1;
        end
      end else begin
        srow_nxt = srow_r + 1'b1;
      end
    end
  end

  always_comb begin
    rd_vld_nxt = rd_vld_r;
    if (issue) begin
      rd_vld_nxt = 1'b1;
    end else if (rd_take) begin
      rd_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (rd_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      t_r         <= '0;
      recv_sel_r  <= 2'd0;
      ready_sel_r <= 2'd1;
      disp_sel_r  <= 2'd2;
      pending_r   <= 1'b0;
      srow_r      <= '0;
      rep_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      t_r         <= t_nxt;
      recv_sel_r  <= recv_sel_nxt;
      ready_sel_r <= ready_sel_nxt;
      disp_sel_r  <= disp_sel_nxt;
      pending_r   <= pending_nxt;
      srow_r      <= srow_nxt;
      rep_r       <= rep_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < LANES; i++) begin
        if (mem_wbe[i]) begin
          pix_mem_r[waddr][i*COLOR_BITS +: COLOR_BITS] <= mem_wdata;
        end
      end
    end
    if (issue) begin
      rd_data_r <= pix_mem_r[raddr];
      rd_meta_r <= meta_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_take) begin
      out_item_r.out_byte  <= shift_byte;
      out_item_r.row       <= rd_meta_r.row;
      out_item_r.plane_bit <= rd_meta_r.plane;
      out_item_r.last      <= rd_meta_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/rgb_led_matrix_bit_angle_scanner.sv =====
// ----------------------------------------------------------------------------
// RGB LED matrix bit angle scanner
// Binary code modulation row scanner with triple buffered frame stores.
// ----------------------------------------------------------------------------
// A tick item is shifted out as ceil(3*floor(LED_COUNT/ROW_COUNT)/8) bytes
// (12 by default), each one read of the pixel memory's single read port, which
// returns the eight colour bytes that feed that byte. A two-entry command queue
// lets the input side keep accepting while a row is being shifted out. After
// reset the three frame stores are cleared one memory word per cycle, and
// in_stall stays high until the clear is done.
module rgb_led_matrix_bit_angle_scanner import rlmbas_pkg::*; #(
  parameter int LED_COUNT  = DEF_LED_COUNT,
  parameter int ROW_COUNT  = DEF_ROW_COUNT,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic q_full;
  logic clear_busy;
  logic push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  rlmbas_front #(
    .LED_COUNT (LED_COUNT),
    .ROW_COUNT (ROW_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .q_full     (q_full),
    .clear_busy (clear_busy),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rlmbas_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  rlmbas_back #(
    .LED_COUNT  (LED_COUNT),
    .ROW_COUNT  (ROW_COUNT),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/rlmbas_checker.sv =====
// ----------------------------------------------------------------------------
// RGB LED matrix scanner checker
// Port level checks on the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "rgb_led_matrix_bit_angle_scanner_assert.svh"

module rlmbas_checker import rlmbas_pkg::*; #(
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `RLMBAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled output item changed")
  `RLMBAS_ASSERT_NEXT(a_row_steady, clk, rst_n, out_valid && !out_stall && !out_item.last, !out_valid || (out_item.row == $past(out_item.row) && out_item.plane_bit == $past(out_item.plane_bit)), "row or plane changed inside a row")
  `RLMBAS_ASSERT_NOW(a_plane_range, clk, rst_n, out_valid, int'(out_item.plane_bit) < COLOR_BITS, "bit plane beyond the colour depth")
  `RLMBAS_ASSERT_AFTER_RESET(a_clear_stall, clk, rst_n, in_stall && !out_valid, "input open or output valid right after reset")

endmodule

bind rgb_led_matrix_bit_angle_scanner rlmbas_checker #(
  .COLOR_BITS (COLOR_BITS)
) u_rlmbas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== bench/tb_rgb_led_matrix_bit_angle_scanner.sv =====
// ----------------------------------------------------------------------------
// Testbench for the RGB LED matrix bit angle scanner
// Sends colour bytes and scan ticks through the input channel. A scoreboard
// keeps its own copy of the three frame stores and the scan position, and
// checks every shift-out byte against the row it should produce. Both channels
// idle and stall at random, and the result side holds off once for a long
// stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb_rgb_led_matrix_bit_angle_scanner;
  import rlmbas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES     = DEF_LED_COUNT * 3;
  localparam int LEDS_PER_ROW    = DEF_LED_COUNT / DEF_ROW_COUNT;
  localparam int ROW_BITS        = LEDS_PER_ROW * 3;
  localparam int ROW_BYTES       = (ROW_BITS + 7) / 8;
  localparam int REP_COUNT       = (1 << DEF_COLOR_BITS) - 1;
  localparam int TOTAL_ITEMS     = 420;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 1_000_000;

  class bcm_scoreboard;
    logic [PIXEL_W-1:0] stores [NUM_STORES][FRAME_BYTES];
    int unsigned        rx_sel;
    int unsigned        ready_sel;
    int unsigned        show_sel;
    int unsigned        wr_pos;
    int unsigned        scan_row;
    int unsigned        rep;
    bit                 pending;
    out_item_t          row_bytes_due[$];
    int unsigned        checked;
    int unsigned        errors;

    function new();
      foreach (stores[s, a]) stores[s][a] = '0;
      rx_sel    = 0;
      ready_sel = 1;
      show_sel  = 2;
      wr_pos    = 0;
      scan_row  = 0;
      rep       = 0;
      pending   = 1'b0;
      checked   = 0;
      errors    = 0;
    endfunction

    function void accept_item(in_item_t it);
      int unsigned        plane;
      int unsigned        pos;
      int unsigned        led;
      int unsigned        held;
      logic [PIXEL_W-1:0] acc;
      out_item_t          want;
      if (it.kind == KIND_LOAD) begin
        stores[rx_sel][wr_pos] = it.pixel_byte;
        wr_pos++;
        if (wr_pos == FRAME_BYTES) begin
          wr_pos    = 0;
          held      = rx_sel;
          rx_sel    = ready_sel;
          ready_sel = held;
          pending   = 1'b1;
        end
        return;
      end
      plane = 0;
      for (int i = 1; i < 32; i++) begin
        if (((rep + 1) >> i) != 0) begin
          plane = i;
        end
      end
      for (int t = 0; t < ROW_BYTES; t++) begin
        acc = '0;
        for (int b = 0; b < 8; b++) begin
          pos = t * 8 + b;
          acc = {acc[PIXEL_W-2:0], 1'b0};
          if (pos < ROW_BITS) begin
            led    = scan_row * LEDS_PER_ROW + pos / 3;
            acc[0] = stores[show_sel][led * 3 + pos % 3][plane];
          end
        end
        want.out_byte  = acc;
        want.row       = ROW_W'(scan_row);
        want.plane_bit = PLANE_W'(plane);
        want.last      = (t == ROW_BYTES - 1);
        row_bytes_due.push_back(want);
      end
      scan_row++;
      if (scan_row >= DEF_ROW_COUNT) begin
        scan_row = 0;
        rep++;
        if (rep >= REP_COUNT) begin
          rep = 0;
          if (pending) begin
            pending   = 1'b0;
            held      = show_sel;
            show_sel  = ready_sel;
            ready_sel = held;
          end
        end
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      checked++;
      if (row_bytes_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: byte %02h row %0d plane %0d last %0b",
                   got.out_byte, got.row, got.plane_bit, got.last);
        end
        return;
      end
      want = row_bytes_due.pop_front();
      if (got.out_byte !== want.out_byte || got.row !== want.row ||
          got.plane_bit !== want.plane_bit || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch at result %0d: expected byte %02h row %0d plane %0d last %0b",
                   checked, want.out_byte, want.row, want.plane_bit, want.last);
          $display("  got byte %02h row %0d plane %0d last %0b",
                   got.out_byte, got.row, got.plane_bit, got.last);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  bcm_scoreboard sb;
  bit            quiet_in;
  int unsigned   items_sent;
  int unsigned   loads_sent;
  int unsigned   ticks_sent;
  int unsigned   cycle_count;

  rgb_led_matrix_bit_angle_scanner DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_item(input logic kind, input logic [PIXEL_W-1:0] value);
    int unsigned gap;
    in_item_t    it;
    gap           = quiet_in ? 0 : pick_gap();
    it.kind       = kind;
    it.pixel_byte = value;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_item(it);
    items_sent++;
    if (kind == KIND_TICK) begin
      ticks_sent++;
    end else begin
      loads_sent++;
    end
    if (items_sent % 64 == 0) begin
      quiet_in = ($urandom_range(0, 2) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_byte(out_item);
    end
  end

  initial begin : result_sink
    int unsigned n;
    int unsigned rounds;
    bit          quiet_out;
    bit          held;
    out_stall = 1'b0;
    quiet_out = 1'b0;
    held      = 1'b0;
    rounds    = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && sb.checked >= 600) begin
        held = 1'b1;
        n    = LONG_HOLD;
      end else begin
        n = quiet_out ? 0 : pick_gap();
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      rounds++;
      if (rounds % 128 == 0) begin
        quiet_out = ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL rgb_led_matrix_bit_angle_scanner");
    $finish;
  end

  initial begin : stimulus
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    sb         = new();
    quiet_in   = 1'b0;
    items_sent = 0;
    loads_sent = 0;
    ticks_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A tick on the cleared stores, bytes at the edges of the range, then more ticks.
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_LOAD, 8'h00);
    send_item(KIND_LOAD, 8'hFF);
    send_item(KIND_LOAD, 8'h80);
    send_item(KIND_LOAD, 8'h01);
    send_item(KIND_LOAD, 8'h55);
    send_item(KIND_LOAD, 8'hAA);
    send_item(KIND_LOAD, 8'h7F);
    send_item(KIND_LOAD, 8'hFE);
    send_item(KIND_TICK, 8'h00);
    repeat (8) send_item(KIND_TICK, PIXEL_W'($urandom));

    // Random mix of loads and ticks for the rest of the run.
    while (items_sent < TOTAL_ITEMS) begin
      send_item($urandom_range(0, 1) ? KIND_TICK : KIND_LOAD, PIXEL_W'($urandom));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.row_bytes_due.size() != 0) @(posedge clk);
    repeat (ROW_BYTES * 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS rgb_led_matrix_bit_angle_scanner");
    end else begin
      $display("FAIL rgb_led_matrix_bit_angle_scanner");
    end
    $finish;
  end

endmodule
